// ===== rtl/lpcd_pkg.sv =====
// ----------------------------------------------------------------------------
// lpcd_pkg
// Shared types and constants of the page cache tag directory.
// ----------------------------------------------------------------------------
package lpcd_pkg;

    localparam int ADDR_W      = 64;
    localparam int LEN_W       = 16;
    localparam int TAG_W       = 52;
    localparam int STAMP_W     = 32;
    localparam int SHIFT_W     = 5;
    localparam int SLOT_FLD_W  = 3;

    localparam logic [SHIFT_W-1:0] SHIFT_MIN   = 5'd12;
    localparam logic [SHIFT_W-1:0] SHIFT_MAX   = 5'd16;
    localparam logic [SHIFT_W-1:0] SHIFT_RESET = 5'd12;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start;
        logic frag;
        logic search;
        logic update;
    } lpcd_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic len_zero;
        logic frag_last;
    } lpcd_sts_t;

endpackage

// ===== rtl/lpcd_ctrl.sv =====
// ----------------------------------------------------------------------------
// lpcd_ctrl
// Sequencer of the directory: walks each request through its page fragments.
// ----------------------------------------------------------------------------
module lpcd_ctrl
    import lpcd_pkg::*;
#(
    parameter int SETTLE_CYCLES = 3
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    output logic      out_valid,
    input  logic      out_stall,
    input  lpcd_sts_t sts,
    output lpcd_cmd_t cmd
);

    localparam int WAIT_W = $clog2(SETTLE_CYCLES + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_FRAG,
        S_SEARCH,
        S_UPDATE
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    logic [WAIT_W-1:0] wait_reg;
    logic [WAIT_W-1:0] wait_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              out_free;

    assign out_free   = !out_valid_reg || !out_stall;
    assign in_stall   = (state_reg != S_IDLE);
    assign out_valid  = out_valid_reg;

    assign cmd.start  = in_valid && (state_reg == S_IDLE);
    assign cmd.frag   = (state_reg == S_FRAG);
    assign cmd.search = (state_reg == S_SEARCH) && (wait_reg == '0);
    assign cmd.update = (state_reg == S_UPDATE) && out_free;

    always_comb
    begin
        state_next     = state_reg;
        wait_next      = wait_reg;
        out_valid_next = out_valid_reg;
        if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (wait_reg != '0)
        begin
            wait_next = wait_reg - 1'b1;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.start && !sts.len_zero)
                begin
                    state_next = S_FRAG;
                end
            end
            S_FRAG:
            begin
                state_next = S_SEARCH;
            end
            S_SEARCH:
            begin
                if (cmd.search)
                begin
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                if (cmd.update)
                begin
                    out_valid_next = 1'b1;
                    // The stamp tree must re-settle after each stamp write.
                    wait_next      = WAIT_W'(SETTLE_CYCLES);
                    state_next     = sts.frag_last ? S_IDLE : S_FRAG;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            wait_reg      <= WAIT_W'(SETTLE_CYCLES);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wait_reg      <= wait_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_update_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_UPDATE) && !out_free |=> (state_reg == S_UPDATE))
        else $error("update left while the output register was still full");

    a_update_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.update |=> out_valid_reg)
        else $error("fragment result not presented after update");

    a_search_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SEARCH) && (wait_reg != '0) |=> (state_reg == S_SEARCH))
        else $error("search proceeded before the stamp tree settled");

    a_start_frag: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start && !sts.len_zero |=> (state_reg == S_FRAG))
        else $error("non-empty request did not start a fragment");

endmodule

// ===== rtl/lpcd_datapath.sv =====
// ----------------------------------------------------------------------------
// lpcd_datapath
// Slot tags, valid bits, stamps, fragment arithmetic and the LRU stamp tree.
// ----------------------------------------------------------------------------
module lpcd_datapath
    import lpcd_pkg::*;
#(
    parameter int NUM_SLOTS = 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [SHIFT_W-1:0]    cfg_data,
    input  logic [ADDR_W-1:0]     address,
    input  logic [LEN_W-1:0]      length,
    input  lpcd_cmd_t             cmd,
    output lpcd_sts_t             sts,
    output logic                  hit,
    output logic [SLOT_FLD_W-1:0] slot,
    output logic [ADDR_W-1:0]     page_address,
    output logic [LEN_W-1:0]      page_offset,
    output logic [LEN_W-1:0]      frag_len,
    output logic [LEN_W-1:0]      dest_offset,
    output logic                  last
);

    localparam int SLOT_W = $clog2(NUM_SLOTS);
    localparam int LEAVES = 1 << SLOT_W;

    typedef struct packed {
        logic               present;
        logic [STAMP_W-1:0] stamp;
        logic [SLOT_W-1:0]  idx;
    } node_t;

    // Configuration and request walk.
    logic [SHIFT_W-1:0] page_shift_reg;
    logic [SHIFT_W-1:0] shift_eff;
    logic [ADDR_W-1:0]  addr_reg;
    logic [LEN_W-1:0]   remain_reg;
    logic [LEN_W-1:0]   done_reg;

    // Current fragment.
    logic [TAG_W-1:0]   frag_tag_reg;
    logic [ADDR_W-1:0]  frag_base_reg;
    logic [LEN_W-1:0]   frag_off_reg;
    logic [LEN_W-1:0]   frag_len_reg;
    logic               frag_last_reg;

    logic [LEN_W:0]     psize;
    logic [LEN_W-1:0]   off_mask;
    logic [LEN_W-1:0]   off_next;
    logic [LEN_W:0]     room;
    logic [LEN_W-1:0]   frag_next;

    // Slot state.
    logic [TAG_W-1:0]   tag_reg   [NUM_SLOTS];
    logic [STAMP_W-1:0] stamp_reg [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] valid_reg;
    logic [STAMP_W-1:0] access_counter_reg;

    logic               match_any;
    logic [SLOT_W-1:0]  match_idx;
    logic               hit_reg;
    logic [SLOT_W-1:0]  hit_slot_reg;
    logic [SLOT_W-1:0]  slot_sel;

    // Output register.
    logic                  out_hit_reg;
    logic [SLOT_FLD_W-1:0] out_slot_reg;
    logic [ADDR_W-1:0]     out_base_reg;
    logic [LEN_W-1:0]      out_off_reg;
    logic [LEN_W-1:0]      out_len_reg;
    logic [LEN_W-1:0]      out_dest_reg;
    logic                  out_last_reg;

    node_t leaf     [LEAVES];
    node_t node_reg [1:LEAVES-1];

    function automatic node_t pick_lru(node_t lo, node_t hi);
        // Ties go to the higher slot index.
        if (!hi.present)
        begin
            return lo;
        end
        else if (!lo.present)
        begin
            return hi;
        end
        else if (lo.stamp < hi.stamp)
        begin
            return lo;
        end
        return hi;
    endfunction

    always_comb
    begin
        priority if (page_shift_reg < SHIFT_MIN)
        begin
            shift_eff = SHIFT_MIN;
        end
        else if (page_shift_reg > SHIFT_MAX)
        begin
            shift_eff = SHIFT_MAX;
        end
        else
        begin
            shift_eff = page_shift_reg;
        end
    end

    assign psize     = (LEN_W+1)'(1) << shift_eff;
    assign off_mask  = LEN_W'(psize - (LEN_W+1)'(1));
    assign off_next  = addr_reg[LEN_W-1:0] & off_mask;
    assign room      = psize - {1'b0, off_next};
    assign frag_next = (room < {1'b0, remain_reg}) ? room[LEN_W-1:0] : remain_reg;

    assign sts.len_zero  = (length == '0);
    assign sts.frag_last = frag_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_shift_reg <= SHIFT_RESET;
        end
        else if (cfg_we)
        begin
            page_shift_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            addr_reg   <= address;
            remain_reg <= length;
            done_reg   <= '0;
        end
        else if (cmd.update)
        begin
            addr_reg   <= addr_reg + ADDR_W'(frag_len_reg);
            remain_reg <= remain_reg - frag_len_reg;
            done_reg   <= done_reg + frag_len_reg;
        end
        if (cmd.frag)
        begin
            frag_tag_reg  <= TAG_W'(addr_reg >> shift_eff);
            frag_base_reg <= {addr_reg[ADDR_W-1:LEN_W], addr_reg[LEN_W-1:0] & ~off_mask};
            frag_off_reg  <= off_next;
            frag_len_reg  <= frag_next;
            frag_last_reg <= (remain_reg == frag_next);
        end
    end

    // Parallel tag compare; the highest matching slot wins.
    always_comb
    begin
        match_any = 1'b0;
        match_idx = '0;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            if (valid_reg[i] && (tag_reg[i] == frag_tag_reg))
            begin
                match_any = 1'b1;
                match_idx = SLOT_W'(i);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.search)
        begin
            hit_reg      <= match_any;
            hit_slot_reg <= match_idx;
        end
    end

    // Registered min tree over the stamps; the root is the LRU victim.
    for (genvar j = 0; j < LEAVES; j++)
    begin : g_leaf
        if (j < NUM_SLOTS)
        begin : g_real
            assign leaf[j] = '{present: 1'b1, stamp: stamp_reg[j], idx: SLOT_W'(j)};
        end
        else
        begin : g_pad
            assign leaf[j] = '{present: 1'b0, stamp: '0, idx: SLOT_W'(j)};
        end
    end

    for (genvar n = 1; n < LEAVES; n++)
    begin : g_node
        if (2 * n >= LEAVES)
        begin : g_bottom
            always_ff @(posedge clk)
            begin
                node_reg[n] <= pick_lru(leaf[2*n-LEAVES], leaf[2*n+1-LEAVES]);
            end
        end
        else
        begin : g_inner
            always_ff @(posedge clk)
            begin
                node_reg[n] <= pick_lru(node_reg[2*n], node_reg[2*n+1]);
            end
        end
    end

    assign slot_sel = hit_reg ? hit_slot_reg : node_reg[1].idx;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg          <= '0;
            access_counter_reg <= '0;
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                stamp_reg[i] <= '0;
            end
        end
        else if (cmd.update)
        begin
            access_counter_reg  <= access_counter_reg + 1'b1;
            stamp_reg[slot_sel] <= access_counter_reg + 1'b1;
            if (!hit_reg)
            begin
                valid_reg[slot_sel] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            if (!hit_reg)
            begin
                tag_reg[slot_sel] <= frag_tag_reg;
            end
            out_hit_reg  <= hit_reg;
            out_slot_reg <= SLOT_FLD_W'(slot_sel);
            out_base_reg <= frag_base_reg;
            out_off_reg  <= frag_off_reg;
            out_len_reg  <= frag_len_reg;
            out_dest_reg <= done_reg;
            out_last_reg <= frag_last_reg;
        end
    end

    assign hit          = out_hit_reg;
    assign slot         = out_slot_reg;
    assign page_address = out_base_reg;
    assign page_offset  = out_off_reg;
    assign frag_len     = out_len_reg;
    assign dest_offset  = out_dest_reg;
    assign last         = out_last_reg;

    a_counter_step: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.update |=> (access_counter_reg == $past(access_counter_reg) + 1'b1))
        else $error("access counter did not advance by one on a fragment");

    a_hit_capture: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.search && match_any |=> hit_reg)
        else $error("tag match not captured as a hit");

    a_fill_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.update |=> valid_reg[$past(slot_sel)])
        else $error("slot not valid after its fragment was served");

endmodule

// ===== rtl/lru_page_cache_directory_top.sv =====
// Each fragment is split off at its page boundary, then searched once the registered
// LRU stamp tree has settled after the previous stamp write, then updated and shown
// as a result; the update waits while the output register is full and stalled.
// The first result of a request that follows straight on the last also waits for the
// stamp tree to settle; a request is accepted only once the previous one has issued all
// fragments. Reset clears valid bits and stamps.
// ----------------------------------------------------------------------------
// lru_page_cache_directory_top
// Tag directory of a small fully associative page cache with LRU replacement.
// ----------------------------------------------------------------------------
module lru_page_cache_directory_top
    import lpcd_pkg::*;
#(
    parameter int NUM_SLOTS = 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [SHIFT_W-1:0]    cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [ADDR_W-1:0]     address,
    input  logic [LEN_W-1:0]      length,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  hit,
    output logic [SLOT_FLD_W-1:0] slot,
    output logic [ADDR_W-1:0]     page_address,
    output logic [LEN_W-1:0]      page_offset,
    output logic [LEN_W-1:0]      frag_len,
    output logic [LEN_W-1:0]      dest_offset,
    output logic                  last
);

    lpcd_cmd_t cmd;
    lpcd_sts_t sts;

    assign cfg_ready = 1'b1;

    lpcd_ctrl #(
        .SETTLE_CYCLES ($clog2(NUM_SLOTS))
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    lpcd_datapath #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_data     (cfg_data),
        .address      (address),
        .length       (length),
        .cmd          (cmd),
        .sts          (sts),
        .hit          (hit),
        .slot         (slot),
        .page_address (page_address),
        .page_offset  (page_offset),
        .frag_len     (frag_len),
        .dest_offset  (dest_offset),
        .last         (last)
    );

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the LRU page cache tag directory. Requests are sent
// in bursts while the result side stalls on its own pattern. Every accepted
// request is split into page fragments by a local directory model, and each
// result beat is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
    import lpcd_pkg::*;

    localparam int NUM_SLOTS   = 8;
    localparam int SETTLE      = $clog2(NUM_SLOTS) + 2 + 8;
    localparam int IDLE_LIMIT  = 2000;
    localparam int HOLD_CYCLES = 300;

    typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PATTERN, STALL_HEAVY} stall_mode_t;

    typedef struct {
        logic                  hit;
        logic [SLOT_FLD_W-1:0] slot;
        logic [ADDR_W-1:0]     page_address;
        logic [LEN_W-1:0]      page_offset;
        logic [LEN_W-1:0]      frag_len;
        logic [LEN_W-1:0]      dest_offset;
        logic                  last;
    } fragment_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [SHIFT_W-1:0]    cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    logic [ADDR_W-1:0]     address;
    logic [LEN_W-1:0]      length;
    logic                  out_valid;
    logic                  out_stall;
    logic                  hit;
    logic [SLOT_FLD_W-1:0] slot;
    logic [ADDR_W-1:0]     page_address;
    logic [LEN_W-1:0]      page_offset;
    logic [LEN_W-1:0]      frag_len;
    logic [LEN_W-1:0]      dest_offset;
    logic                  last;

    // Directory model.
    logic [TAG_W-1:0]      cache_tag   [NUM_SLOTS];
    logic                  cache_valid [NUM_SLOTS];
    logic [STAMP_W-1:0]    cache_stamp [NUM_SLOTS];
    logic [STAMP_W-1:0]    access_count;
    logic [SHIFT_W-1:0]    page_shift_q;

    fragment_t             expected_frags[$];
    int                    mismatch_count;
    int                    burst_left;
    bit                    sender_steady;
    stall_mode_t           stall_mode;
    int                    hold_request;
    int                    hold_left;
    int                    pattern_phase;
    logic [ADDR_W-1:0]     page_pool[12];

    lru_page_cache_directory_top #(
        .NUM_SLOTS(NUM_SLOTS)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .address     (address),
        .length      (length),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .hit         (hit),
        .slot        (slot),
        .page_address(page_address),
        .page_offset (page_offset),
        .frag_len    (frag_len),
        .dest_offset (dest_offset),
        .last        (last)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // Model of the directory
    // ------------------------------------------------------------------------
    task automatic reset_directory();
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            cache_tag[i]   = '0;
            cache_valid[i] = 1'b0;
            cache_stamp[i] = '0;
        end
        access_count = '0;
        page_shift_q = SHIFT_RESET;
    endtask

    task automatic predict_request(input logic [ADDR_W-1:0] start_addr,
                                   input logic [LEN_W-1:0] req_len);
        logic [ADDR_W-1:0]  addr;
        logic [ADDR_W-1:0]  psize;
        logic [ADDR_W-1:0]  off;
        logic [ADDR_W-1:0]  room;
        logic [TAG_W-1:0]   tag;
        logic [STAMP_W-1:0] best;
        int unsigned        remain;
        int unsigned        done;
        int unsigned        frag;
        int unsigned        eff;
        int                 chosen;
        bit                 found;
        fragment_t          f;

        addr   = start_addr;
        remain = 32'(req_len);
        done   = 0;
        if (page_shift_q < SHIFT_MIN)
            eff = 32'(SHIFT_MIN);
        else if (page_shift_q > SHIFT_MAX)
            eff = 32'(SHIFT_MAX);
        else
            eff = 32'(page_shift_q);
        psize = 64'd1 << eff;

        while (remain != 0)
        begin
            off  = addr & (psize - 64'd1);
            tag  = TAG_W'(addr >> eff);
            room = psize - off;
            frag = (room < 64'(remain)) ? 32'(room) : remain;

            // Downward scan: the first valid match wins, otherwise the
            // lowest stamp, with ties going to the highest slot.
            found  = 1'b0;
            chosen = NUM_SLOTS - 1;
            best   = cache_stamp[NUM_SLOTS-1];
            for (int i = NUM_SLOTS - 1; i >= 0; i--)
            begin
                if (!found)
                begin
                    if (cache_valid[i] && cache_tag[i] == tag)
                    begin
                        found  = 1'b1;
                        chosen = i;
                    end
                    else if (cache_stamp[i] < best)
                    begin
                        best   = cache_stamp[i];
                        chosen = i;
                    end
                end
            end

            if (!found)
            begin
                cache_valid[chosen] = 1'b1;
                cache_tag[chosen]   = tag;
            end
            access_count        = access_count + 1;
            cache_stamp[chosen] = access_count;

            remain         = remain - frag;
            f.hit          = found;
            f.slot         = SLOT_FLD_W'(chosen);
            f.page_address = addr - off;
            f.page_offset  = off[LEN_W-1:0];
            f.frag_len     = LEN_W'(frag);
            f.dest_offset  = LEN_W'(done);
            f.last         = (remain == 0);
            expected_frags.push_back(f);

            done = done + frag;
            addr = addr + 64'(frag);
        end
    endtask

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [63:0] want,
                                   input logic [63:0] got);
        mismatch_count++;
        $display("mismatch: %s expected %0h got %0h", what, want, got);
    endtask

    always @(posedge clk)
    begin : check_results
        fragment_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_frags.size() == 0)
                report_mismatch("unexpected result beat, page_address", '0, page_address);
            else
            begin
                want = expected_frags.pop_front();
                if (hit !== want.hit)
                    report_mismatch("hit", 64'(want.hit), 64'(hit));
                if (slot !== want.slot)
                    report_mismatch("slot", 64'(want.slot), 64'(slot));
                if (page_address !== want.page_address)
                    report_mismatch("page_address", want.page_address, page_address);
                if (page_offset !== want.page_offset)
                    report_mismatch("page_offset", 64'(want.page_offset), 64'(page_offset));
                if (frag_len !== want.frag_len)
                    report_mismatch("frag_len", 64'(want.frag_len), 64'(frag_len));
                if (dest_offset !== want.dest_offset)
                    report_mismatch("dest_offset", 64'(want.dest_offset), 64'(dest_offset));
                if (last !== want.last)
                    report_mismatch("last", 64'(want.last), 64'(last));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result side stalls; a long hold-off is counted down here when requested.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (hold_request != 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        pattern_phase++;
        if (hold_left != 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            case (stall_mode)
                STALL_RANDOM:  out_stall <= ($urandom_range(0, 2) == 0);
                STALL_PATTERN: out_stall <= ((pattern_phase % 7) < 3);
                STALL_HEAVY:   out_stall <= ($urandom_range(0, 3) != 0);
                default:       out_stall <= 1'b0;
            endcase
        end
    end

    // Ends the run when no beat moves on any channel for too long.
    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        wait (rst_n === 1'b1);
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("timeout: no beat accepted for %0d cycles", IDLE_LIMIT);
        $display("FAIL");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    // Called at a falling edge; returns at a falling edge.
    task automatic send_request(input logic [ADDR_W-1:0] a, input logic [LEN_W-1:0] l);
        int gap;
        in_valid <= 1'b1;
        address  <= a;
        length   <= l;
        do
            @(posedge clk);
        while (in_stall);
        predict_request(a, l);
        @(negedge clk);
        if (sender_steady || burst_left > 0)
        begin
            if (burst_left > 0)
                burst_left--;
        end
        else
        begin
            burst_left = $urandom_range(0, 12);
            gap        = $urandom_range(1, 6);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // Drains every expected beat; the extra cycles cover zero-length requests
    // that may still be in flight with nothing to wait for.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_frags.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_page_shift(input logic [SHIFT_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        page_shift_q = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_request(output logic [ADDR_W-1:0] a, output logic [LEN_W-1:0] l);
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 75)
            a = (page_pool[$urandom_range(0, 11)] & ~64'hFFFF) +
                64'($urandom_range(0, 32'h1FFFF));
        else if (pick < 85)
            a = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 32'h1FFFF));
        else
            a = {$urandom, $urandom};

        pick = $urandom_range(0, 99);
        if (pick < 8)
            l = '0;
        else if (pick < 70)
            l = LEN_W'($urandom_range(1, 9000));
        else if (pick < 92)
            l = LEN_W'($urandom);
        else
            l = 16'hFFFF;
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Page size 4 KiB straight out of reset: fills, hits, eviction, extremes.
    task automatic test_directed();
        stall_mode = STALL_RANDOM;
        send_request(64'h0, 16'h0);                       // zero length
        send_request(64'h0, 16'h1);                       // first fill, all stamps tie
        send_request(64'h0, 16'h1);                       // hit
        send_request(64'hFFF, 16'h2);                     // straddles two pages
        send_request(64'h2000, 16'h6000);                 // fills the remaining slots
        send_request(64'h8000, 16'h1);                    // evicts the oldest page
        send_request(64'h0, 16'h10);                      // page 0 was evicted
        send_request(64'h123, 16'hFFFF);                  // most fragments
        send_request(64'hFFFF_FFFF_FFFF_F800, 16'h1000);  // address wraps to zero
        send_request(64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF);
        send_request(64'hFFFF_FFFF_FFFF_FFFF, 16'h0);
        send_request(64'hAAAA_5555_AAAA_5555, 16'h5555);
        send_request(64'h5555_AAAA_5555_AAAA, 16'hAAAA);
        send_request(64'h0, 16'h1000);                    // exactly one page
        wait_idle();
    endtask

    // Register values below, across and above the clamped range; the
    // directory is not flushed, so old tags meet the new page size.
    task automatic test_page_shift_sweep();
        logic [SHIFT_W-1:0] shifts[10] = '{5'd0, 5'd11, 5'd12, 5'd13, 5'd14,
                                           5'd15, 5'd16, 5'd17, 5'd31, 5'd12};
        stall_mode = STALL_PATTERN;
        foreach (shifts[k])
        begin
            write_page_shift(shifts[k]);
            send_request(64'h0010_0000, 16'h1);
            send_request(64'h0001_0000, 16'h2345);
            send_request(64'h0000_F000, 16'h2000);
            wait_idle();
        end
    endtask

    task automatic test_random_traffic();
        logic [ADDR_W-1:0] a;
        logic [LEN_W-1:0]  l;
        for (int k = 0; k < 12; k++)
            page_pool[k] = {$urandom, $urandom};
        for (int phase = 0; phase < 6; phase++)
        begin
            if ($urandom_range(0, 4) == 0)
                write_page_shift(SHIFT_W'($urandom));
            else
                write_page_shift(SHIFT_W'($urandom_range(SHIFT_MIN, SHIFT_MAX)));
            stall_mode    = stall_mode_t'($urandom_range(0, 3));
            sender_steady = (phase == 2);
            for (int n = 0; n < 20; n++)
            begin
                random_request(a, l);
                send_request(a, l);
            end
            wait_idle();
        end
        sender_steady = 1'b0;
    endtask

    // Result side holds off for a long stretch while requests keep coming.
    task automatic test_backpressure();
        stall_mode    = STALL_NONE;
        sender_steady = 1'b1;
        write_page_shift(SHIFT_MIN);
        hold_request = HOLD_CYCLES;
        for (int n = 0; n < 10; n++)
            send_request({$urandom, $urandom}, LEN_W'($urandom_range(8000, 30000)));
        sender_steady = 1'b0;
        stall_mode    = STALL_RANDOM;
        wait_idle();
    endtask

    initial
    begin
        rst_n          = 1'b0;
        cfg_valid      = 1'b0;
        cfg_data       = '0;
        in_valid       = 1'b0;
        address        = '0;
        length         = '0;
        out_stall      = 1'b0;
        mismatch_count = 0;
        burst_left     = 0;
        sender_steady  = 1'b0;
        stall_mode     = STALL_NONE;
        hold_request   = 0;
        hold_left      = 0;
        pattern_phase  = 0;
        reset_directory();

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed();
        test_page_shift_sweep();
        test_random_traffic();
        test_backpressure();

        if (expected_frags.size() != 0)
            report_mismatch("results never delivered", 64'(expected_frags.size()), '0);

        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
